@@ design/midpoint_circle_rasterizer_unit_defines.svh @@
// assertion macros shared by the circle rasterizer modules
`ifndef MIDPOINT_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define MCR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mcr check failed");

// next-cycle implication, checked outside reset
`define MCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mcr check failed");

`endif

@@ design/mcr_pkg.sv @@
// shared types and constants of the midpoint circle rasterizer
`default_nettype none

package mcr_pkg;

  localparam int ScreenWidthDef  = 240;
  localparam int ScreenHeightDef = 160;
  localparam int MaxRadiusDef    = 63;

  // loop budget per circle
  localparam int MaxSteps = 46;
  localparam int StepW    = $clog2(MaxSteps + 1);

  // dx/dy cover radii up to 89 plus one step past the end
  localparam int DistW  = 8;
  // decision value stays within about +-4r+10
  localparam int DecW   = 12;
  // point coordinates: center 0..255 plus/minus distance
  localparam int CoordW = 10;
  // coordinate compare width, holds screen sizes up to 1024
  localparam int CmpW   = 12;

  localparam int OffW      = 16;
  localparam int NumPoints = 8;
  localparam int ColorW    = 15;

  localparam int InDataW  = 40;
  localparam int OutDataW = 152;

  localparam int QueueDepth = 2;

  typedef struct packed {
    logic [7:0]              cx;
    logic [7:0]              cy;
    logic signed [DistW-1:0] dy;
    logic signed [DecW-1:0]  dec;
    logic [ColorW-1:0]       color;
  } req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qflag_t;

  typedef struct packed {
    logic [ColorW-1:0]                pixel_color;
    logic [NumPoints-1:0]             visible_mask;
    logic [NumPoints-1:0][OffW-1:0]   offsets;
    logic                             last_step;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

endpackage

`default_nettype wire

@@ design/mcr_queue.sv @@
// small request queue between the front and back ends
`default_nettype none
`include "midpoint_circle_rasterizer_unit_defines.svh"

module mcr_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire mcr_pkg::req_t push_data,
  input  wire logic          pop,
  output mcr_pkg::req_t      head,
  output mcr_pkg::qflag_t    flags
);
  import mcr_pkg::*;

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  req_t            slot_r [QueueDepth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  assign head        = slot_r[rd_ptr_r];
  assign flags.full  = (cnt_r == CntW'(QueueDepth));
  assign flags.empty = (cnt_r == '0);

  `MCR_ASSERT_NOW(a_no_overflow, clk, rst_n, push, !flags.full || pop)
  `MCR_ASSERT_NOW(a_no_underflow, clk, rst_n, pop, !flags.empty)
  `MCR_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, cnt_r <= CntW'(QueueDepth))

endmodule

`default_nettype wire

@@ design/mcr_front.sv @@
// front end: takes circle requests, clamps radius, sets up the loop
`default_nettype none

module mcr_front #(
  parameter int MAX_RADIUS = mcr_pkg::MaxRadiusDef
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [mcr_pkg::InDataW-1:0]  in_tdata,
  input  wire mcr_pkg::qflag_t              flags,
  output logic                              push,
  output mcr_pkg::req_t                     push_data
);
  import mcr_pkg::*;

  localparam logic [DistW-1:0] RadLimit = DistW'(MAX_RADIUS);

  logic [DistW-1:0] rad_raw;
  logic [DistW-1:0] rad;
  logic             rst_hold_r;

  // hold off requests for the cycle that leaves reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_hold_r <= 1'b1;
    end else begin
      rst_hold_r <= 1'b0;
    end
  end

  assign in_tready = !flags.full && !rst_hold_r;
  assign push      = in_tvalid && in_tready;

  assign rad_raw = DistW'(in_tdata[21:16]);
  assign rad     = (rad_raw > RadLimit) ? RadLimit : rad_raw;

  always_comb begin
    push_data.cx    = in_tdata[7:0];
    push_data.cy    = in_tdata[15:8];
    push_data.dy    = $signed(rad);
    // decision starts at 3 - 2r
    push_data.dec   = DecW'(3) - (DecW'(rad) <<< 1);
    push_data.color = in_tdata[36:22];
  end

endmodule

`default_nettype wire

@@ design/mcr_back.sv @@
// back end: midpoint loop, one octant step per cycle into an output register, while that register is free
`default_nettype none
`include "midpoint_circle_rasterizer_unit_defines.svh"

module mcr_back #(
  parameter int SCREEN_WIDTH  = mcr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = mcr_pkg::ScreenHeightDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire mcr_pkg::req_t                 head,
  input  wire mcr_pkg::qflag_t               flags,
  output logic                               pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [mcr_pkg::OutDataW-1:0]       out_tdata,
  output logic                               out_tlast
);
  import mcr_pkg::*;

  localparam logic signed [CmpW-1:0] WidthLim  = CmpW'(SCREEN_WIDTH);
  localparam logic signed [CmpW-1:0] HeightLim = CmpW'(SCREEN_HEIGHT);
  localparam logic [OffW-1:0]        WidthK    = OffW'(SCREEN_WIDTH);

  state_t state_r, state_nxt;

  logic [7:0]              cx_r, cy_r;
  logic [ColorW-1:0]       color_r;
  logic signed [DistW-1:0] dx_r, dy_r, dx_nxt, dy_nxt;
  logic signed [DecW-1:0]  dec_r, dec_nxt;
  logic [StepW-1:0]        n_r, n_nxt;
  logic                    out_valid_r, out_valid_nxt;
  res_t                    res_r, res_nxt;

  logic                    slot_free;
  logic                    step_en;
  logic                    step_last;

  logic signed [CoordW-1:0] cxs, cys, dxs, dys;
  logic signed [CoordW-1:0] px [NumPoints];
  logic signed [CoordW-1:0] py [NumPoints/2];
  logic signed [CmpW-1:0]   pxc, pyc;
  logic [NumPoints/2-1:0]   row_ok;
  logic [OffW-1:0]          row_base [NumPoints/2];

  assign slot_free = !out_valid_r || out_tready;
  assign step_en   = (state_r == ST_RUN) && slot_free;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!flags.empty) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (step_en && step_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop = 1'b0;
    unique case (state_r)
      ST_IDLE: pop = !flags.empty;
      ST_RUN:  pop = 1'b0;
      default: pop = 1'b0;
    endcase
  end

  // decision update uses dx/dy from before the step
  always_comb begin
    dx_nxt = dx_r + 1'b1;
    n_nxt  = n_r + 1'b1;
    if (dec_r < 0) begin
      dec_nxt = dec_r + (DecW'(dx_r) <<< 2) + DecW'(6);
      dy_nxt  = dy_r;
    end else begin
      dec_nxt = dec_r + ((DecW'(dx_r) - DecW'(dy_r)) <<< 2) + DecW'(10);
      dy_nxt  = dy_r - 1'b1;
    end
    step_last = (dx_nxt > dy_nxt) || (n_nxt >= StepW'(MaxSteps));
  end

  // eight mirrored points; rows shared by pairs of points
  always_comb begin
    cxs = $signed(CoordW'(cx_r));
    cys = $signed(CoordW'(cy_r));
    dxs = CoordW'(dx_r);
    dys = CoordW'(dy_r);

    py[0] = cys + dys;
    py[1] = cys - dys;
    py[2] = cys + dxs;
    py[3] = cys - dxs;

    px[0] = cxs + dxs;
    px[1] = cxs - dxs;
    px[2] = cxs + dxs;
    px[3] = cxs - dxs;
    px[4] = cxs + dys;
    px[5] = cxs - dys;
    px[6] = cxs + dys;
    px[7] = cxs - dys;

    for (int r = 0; r < NumPoints/2; r++) begin
      pyc         = CmpW'(py[r]);
      row_ok[r]   = (pyc >= 0) && (pyc < HeightLim);
      row_base[r] = OffW'(OffW'(py[r]) * WidthK);
    end

    res_nxt.pixel_color = color_r;
    res_nxt.last_step   = step_last;
    for (int i = 0; i < NumPoints; i++) begin
      pxc = CmpW'(px[i]);
      res_nxt.visible_mask[i] = row_ok[i/2] && (pxc >= 0) && (pxc < WidthLim);
      res_nxt.offsets[i]      = res_nxt.visible_mask[i]
                              ? OffW'(row_base[i/2] + OffW'(px[i])) : '0;
    end
  end

  assign out_valid_nxt = step_en ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx_r    <= head.cx;
      cy_r    <= head.cy;
      color_r <= head.color;
      dx_r    <= '0;
      dy_r    <= head.dy;
      dec_r   <= head.dec;
      n_r     <= '0;
    end else if (step_en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      dec_r <= dec_nxt;
      n_r   <= n_nxt;
    end
    if (step_en) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = res_r.last_step;
  assign out_tdata  = {1'b0, res_r.pixel_color, res_r.visible_mask, res_r.offsets};

  `MCR_ASSERT_NOW(a_run_in_octant, clk, rst_n, state_r == ST_RUN, dx_r <= dy_r)
  `MCR_ASSERT_NOW(a_run_budget, clk, rst_n, state_r == ST_RUN, n_r < StepW'(MaxSteps))
  `MCR_ASSERT_NEXT(a_pop_starts, clk, rst_n, pop, state_r == ST_RUN)

endmodule

`default_nettype wire

@@ design/midpoint_circle_rasterizer_unit.sv @@
// top level of the midpoint circle rasterizer. A request on the in_ channel
// gives a circle center, a radius (clamped to MAX_RADIUS) and a color; the
// block answers with one result per octant step of the midpoint loop, each
// holding the eight mirrored points as framebuffer offsets y*SCREEN_WIDTH+x,
// a visibility mask (off-screen points read offset 0), the color, and tlast
// on the final step. A circle of radius r is loaded in the idle state, then
// runs one step per result, with steps about r/1.41 + 1 and at most 46; the
// single step datapath in the back end sets the pace, and within a circle
// results leave at one per cycle while out_tready stays high.
// The front end accepts requests into a two-entry queue while the back end
// is still drawing, so up to two further circles wait without stalling in_.
`default_nettype none

module midpoint_circle_rasterizer_unit #(
  parameter int SCREEN_WIDTH  = mcr_pkg::ScreenWidthDef,
  parameter int SCREEN_HEIGHT = mcr_pkg::ScreenHeightDef,
  parameter int MAX_RADIUS    = mcr_pkg::MaxRadiusDef
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // circle request channel
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  // center_x [7:0], center_y [15:8], radius [21:16], color [36:22], zero fill
  input  wire logic [mcr_pkg::InDataW-1:0]   in_tdata,
  // result channel
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // offset_0 [15:0] .. offset_7 [127:112], visible_mask [135:128],
  // pixel_color [150:136], zero fill
  output logic [mcr_pkg::OutDataW-1:0]       out_tdata,
  // last_step
  output logic                               out_tlast
);
  import mcr_pkg::*;

  // request path from front end through the queue
  logic   push;
  req_t   push_data;
  logic   pop;
  req_t   head;
  qflag_t flags;

  // front end: accepts requests and prepares the loop start values
  mcr_front #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .flags     (flags),
    .push      (push),
    .push_data (push_data)
  );

  // decouples the two ends so each stalls on its own
  mcr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .flags     (flags)
  );

  // back end: runs the loop and holds each result in the output register
  mcr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .flags      (flags),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

@@ tb/tb_midpoint_circle_rasterizer_unit.sv @@
// self-checking testbench of the midpoint circle rasterizer unit
`default_nettype none

module tb_midpoint_circle_rasterizer_unit;

  import mcr_pkg::*;

  // cycles without any transfer before the run is declared hung
  localparam int StallLimit = 3000;
  // quiet cycles after the last result
  localparam int TailCycles = 60;
  localparam int LongHold   = 400;
  localparam int MaxReports = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tlast;

  // expected loop steps, oldest first
  res_t circle_steps[$];

  int err_count  = 0;
  int miss_count = 0;

  // idling controls for the two sides
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_wait    = 0;
  int hold_left  = 0;

  midpoint_circle_rasterizer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial begin
    forever begin
      #5 clk = ~clk;
    end
  end

  // expand one circle request into its loop steps
  function automatic void predict_circle(input logic [7:0] cx, input logic [7:0] cy,
                                         input logic [5:0] rad, input logic [14:0] col);
    int   r;
    int   dx;
    int   dy;
    int   dec;
    int   n;
    int   px;
    int   py;
    int   sx[8];
    int   sy[8];
    res_t step;
    r   = int'(rad);
    if (r > MaxRadiusDef) begin
      r = MaxRadiusDef;
    end
    dx  = 0;
    dy  = r;
    dec = 3 - 2 * r;
    n   = 0;
    while (dx <= dy && n < MaxSteps) begin
      // mirror order: four points around (dx,dy), then four around (dy,dx)
      sx = '{dx, -dx, dx, -dx, dy, -dy, dy, -dy};
      sy = '{dy, dy, -dy, -dy, dx, dx, -dx, -dx};
      step = '0;
      for (int i = 0; i < NumPoints; i++) begin
        px = int'(cx) + sx[i];
        py = int'(cy) + sy[i];
        // off-screen points keep offset 0 and a clear mask bit
        if (px >= 0 && px < ScreenWidthDef && py >= 0 && py < ScreenHeightDef) begin
          step.visible_mask[i] = 1'b1;
          step.offsets[i]      = 16'(py * ScreenWidthDef + px);
        end
      end
      step.pixel_color = col;
      if (dec < 0) begin
        dec = dec + 4 * dx + 6;
        dx  = dx + 1;
      end else begin
        dec = dec + 4 * (dx - dy) + 10;
        dx  = dx + 1;
        dy  = dy - 1;
      end
      n = n + 1;
      step.last_step = (dx > dy || n >= MaxSteps);
      circle_steps.push_back(step);
    end
  endfunction

  // offer one circle request, called and returning at a falling edge
  task automatic send_circle(input logic [7:0] cx, input logic [7:0] cy,
                             input logic [5:0] rad, input logic [14:0] col);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, col, rad, cy, cx};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    predict_circle(cx, cy, rad, col);
    @(negedge clk);
  endtask

  // drop the request line and wait until every expected step has arrived
  task automatic settle;
    in_tvalid <= 1'b0;
    while (circle_steps.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [15:0] want,
                               input logic [15:0] got);
    err_count++;
    miss_count++;
    if (miss_count <= MaxReports) begin
      $display("mismatch %s: expected %h got %h", what, want, got);
    end
  endtask

  // random circle, mostly on screen, some centers past the screen edge
  task automatic send_random_circle;
    logic [7:0]  cx;
    logic [7:0]  cy;
    logic [5:0]  rad;
    int          pick;
    if ($urandom_range(0, 99) < 85) begin
      cx = 8'($urandom_range(0, 239));
      cy = 8'($urandom_range(0, 159));
    end else begin
      cx = 8'($urandom_range(0, 255));
      cy = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      rad = 6'($urandom_range(0, 3));
    end else if (pick < 35) begin
      rad = 6'd63;
    end else begin
      rad = 6'($urandom_range(0, 63));
    end
    send_circle(cx, cy, rad, 15'($urandom_range(0, 32767)));
  endtask

  // field extremes, screen corners, zero radius, centers past the screen
  task automatic test_directed;
    send_circle(8'd120, 8'd80, 6'd0, 15'h0000);
    send_circle(8'd120, 8'd80, 6'd63, 15'h7fff);
    send_circle(8'd0, 8'd0, 6'd0, 15'h001f);
    send_circle(8'd0, 8'd0, 6'd63, 15'h03e0);
    send_circle(8'd239, 8'd159, 6'd63, 15'h7c00);
    send_circle(8'd239, 8'd0, 6'd10, 15'h5555);
    send_circle(8'd0, 8'd159, 6'd10, 15'h2aaa);
    send_circle(8'd120, 8'd80, 6'd1, 15'h7fff);
    send_circle(8'd120, 8'd80, 6'd2, 15'h0001);
    send_circle(8'd120, 8'd80, 6'd3, 15'h4000);
    // centers outside the screen
    send_circle(8'd255, 8'd255, 6'd0, 15'h1234);
    send_circle(8'd255, 8'd255, 6'd5, 15'h6789);
    send_circle(8'd255, 8'd255, 6'd63, 15'h7fff);
    send_circle(8'd240, 8'd160, 6'd20, 15'h0f0f);
    send_circle(8'd128, 8'd255, 6'd40, 15'h70f0);
    send_circle(8'd60, 8'd40, 6'd32, 15'h0000);
    settle();
  endtask

  // receiver blocks for a long stretch while requests keep coming
  task automatic test_output_stall;
    tx_idle_en = 1'b0;
    @(posedge clk);
    hold_left = LongHold;
    @(negedge clk);
    for (int i = 0; i < 10; i++) begin
      send_random_circle();
    end
    tx_idle_en = 1'b1;
    settle();
  endtask

  // back-to-back traffic with no idling on either side
  task automatic test_full_rate;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int i = 0; i < 40; i++) begin
      send_random_circle();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    settle();
  endtask

  // sender waits for the block to empty between short bursts
  task automatic test_sender_pause;
    for (int i = 0; i < 5; i++) begin
      for (int j = 0; j < 4; j++) begin
        send_random_circle();
      end
      settle();
    end
  endtask

  // long random run, idling switched in chunks so some stretches run flat out
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      send_random_circle();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    settle();
  endtask

  // result side ready, with per-result waits and the long hold-off
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest expected step
  always @(posedge clk) begin : check_results
    res_t got;
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      rx_wait = rx_idle_en ? $urandom_range(0, 18) : 0;
      got.offsets      = out_tdata[127:0];
      got.visible_mask = out_tdata[135:128];
      got.pixel_color  = out_tdata[150:136];
      got.last_step    = out_tlast;
      if (circle_steps.size() == 0) begin
        note_mismatch("result with no request pending", 16'h0, got.offsets[0]);
      end else begin
        want = circle_steps.pop_front();
        for (int i = 0; i < NumPoints; i++) begin
          if (got.offsets[i] !== want.offsets[i]) begin
            note_mismatch($sformatf("offset_%0d", i), want.offsets[i], got.offsets[i]);
          end
        end
        if (got.visible_mask !== want.visible_mask) begin
          note_mismatch("visible_mask", 16'(want.visible_mask), 16'(got.visible_mask));
        end
        if (got.pixel_color !== want.pixel_color) begin
          note_mismatch("pixel_color", 16'(want.pixel_color), 16'(got.pixel_color));
        end
        if (got.last_step !== want.last_step) begin
          note_mismatch("last_step", 16'(want.last_step), 16'(got.last_step));
        end
      end
    end
  end

  // hang detection: cycles with no transfer on either channel
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  // main sequence
  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_output_stall();
    test_full_rate();
    test_sender_pause();
    test_random(330);
    repeat (TailCycles) @(negedge clk);
    // leftovers and anything late count as failures
    err_count += circle_steps.size();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/mcr_pkg.sv
design/mcr_queue.sv
design/mcr_front.sv
design/mcr_back.sv
design/midpoint_circle_rasterizer_unit.sv
tb/tb_midpoint_circle_rasterizer_unit.sv
